// ----- rtl/sfss_pkg.sv -----
// Package for the full-step stepper sequencer: request codes, register
// indexes, reset defaults and the coil pattern function. No dependencies.
package sfss_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF    = 32;
    localparam int INTERVAL_WIDTH     = 32;
    localparam int MAX_POS_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH     = 32;

    localparam logic [INTERVAL_WIDTH-1:0] DEF_STEP_INTERVAL = 32'd5000;
    localparam logic [MAX_POS_WIDTH-1:0]  DEF_MAX_POSITION  = 16'd8192;

    typedef logic [2:0] phase_t;
    localparam phase_t PHASE_FIRST = 3'd0;
    localparam phase_t PHASE_LAST  = 3'd3;
    localparam phase_t PHASE_IDLE  = 3'd4;

    typedef enum logic [2:0] {
        REQ_NONE  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_CW    = 3'd3,
        REQ_CCW   = 3'd4
    } req_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_STEP_INTERVAL = 2'd0,
        CFG_MAX_POSITION  = 2'd1
    } cfg_index_t;

    // two coils on: A+C, B+C, B+D, A+D
    function automatic logic [3:0] coil_pattern(input phase_t ph);
        logic [3:0] pat;
        case (ph)
            3'd0:    pat = 4'd5;
            3'd1:    pat = 4'd6;
            3'd2:    pat = 4'd10;
            3'd3:    pat = 4'd9;
            default: pat = 4'd0;
        endcase
        return pat;
    endfunction

endpackage

// ----- rtl/stepper_full_step_sequencer_top.sv -----
// Full-step stepper sequencer top level: input register, one pass of step
// logic, result register. Depends on sfss_pkg.
// An accepted item passes the input register, then the result register; a stalled
// result register holds the item in the input register until the sink takes it.
// Throughput: one item per cycle while the sink does not stall; the result register
// and the input register let a new item enter while a result waits for the sink.
// Reset (rst_n low, async): stopped, phase 0, position 0, timer 0, coils off,
// interval 5000 us, max position 8192. No clearing pass; ready right after reset.
module stepper_full_step_sequencer_top #(
    parameter int POSITION_WIDTH = sfss_pkg::POSITION_WIDTH_DEF,
    parameter int TIMER_WIDTH    = sfss_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfss_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 us_tick,
    input  logic [2:0]                           req_type,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           coil_drive,
    output logic [POSITION_WIDTH-1:0]            position,
    output logic                                 running,
    output logic                                 stepped
);
    import sfss_pkg::*;

    localparam int CMP_WIDTH = (POSITION_WIDTH > MAX_POS_WIDTH) ? POSITION_WIDTH
                                                                : MAX_POS_WIDTH;

    // configuration
    logic [INTERVAL_WIDTH-1:0] interval_reg;
    logic [MAX_POS_WIDTH-1:0]  max_pos_reg;

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_tick_reg;
    logic [2:0] s1_req_reg;

    // block state
    logic                      run_reg, run_next;
    phase_t                    phase_reg, phase_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [TIMER_WIDTH-1:0]    elapsed_reg, elapsed_next;
    logic [3:0]                latch_reg, latch_next;

    // result stage
    logic                      out_valid_reg, out_valid_next;
    logic [3:0]                out_coil_reg;
    logic [POSITION_WIDTH-1:0] out_pos_reg;
    logic                      out_run_reg;
    logic                      out_step_reg;

    logic                      in_take;
    logic                      adv;
    logic                      step_c;
    logic [TIMER_WIDTH-1:0]    elapsed_t;
    logic                      interval_done;
    logic                      cw_ok;
    logic                      ccw_ok;

    assign cfg_ready = 1'b1;

    assign adv      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = adv ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0
                                                                         : out_valid_reg);

    // tick is counted before the request is judged
    assign elapsed_t     = (s1_tick_reg && !(&elapsed_reg)) ? elapsed_reg + 1'b1
                                                            : elapsed_reg;
    assign interval_done = INTERVAL_WIDTH'(elapsed_t) >= interval_reg;
    assign cw_ok  = run_reg && (CMP_WIDTH'(pos_reg) < CMP_WIDTH'(max_pos_reg))
                    && !(&pos_reg);
    assign ccw_ok = run_reg && (pos_reg != '0);

    always_comb
    begin
        run_next     = run_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        elapsed_next = elapsed_t;
        latch_next   = latch_reg;
        step_c       = 1'b0;
        unique case (s1_req_reg)
            REQ_START:
            begin
                run_next = 1'b1;
            end
            REQ_STOP:
            begin
                run_next = 1'b0;
            end
            REQ_CW:
            begin
                if (cw_ok)
                begin
                    if (interval_done)
                    begin
                        phase_next   = (phase_reg >= PHASE_LAST) ? PHASE_FIRST
                                                                 : phase_reg + 3'd1;
                        latch_next   = coil_pattern(phase_next);
                        elapsed_next = '0;
                        pos_next     = pos_reg + 1'b1;
                        step_c       = 1'b1;
                    end
                end
                else
                begin
                    run_next   = 1'b0;
                    phase_next = PHASE_IDLE;
                    latch_next = 4'd0;
                end
            end
            REQ_CCW:
            begin
                if (ccw_ok)
                begin
                    if (interval_done)
                    begin
                        phase_next   = (phase_reg == PHASE_FIRST || phase_reg > PHASE_LAST)
                                       ? PHASE_LAST : phase_reg - 3'd1;
                        latch_next   = coil_pattern(phase_next);
                        elapsed_next = '0;
                        pos_next     = pos_reg - 1'b1;
                        step_c       = 1'b1;
                    end
                end
                else
                begin
                    run_next   = 1'b0;
                    phase_next = PHASE_IDLE;
                    latch_next = 4'd0;
                end
            end
            default:
            begin
                // no request, unused codes included
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= DEF_STEP_INTERVAL;
            max_pos_reg   <= DEF_MAX_POSITION;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
            phase_reg     <= PHASE_FIRST;
            pos_reg       <= '0;
            elapsed_reg   <= '0;
            latch_reg     <= 4'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STEP_INTERVAL)
                    interval_reg <= cfg_data;
                else if (cfg_index == CFG_MAX_POSITION)
                    max_pos_reg <= cfg_data[MAX_POS_WIDTH-1:0];
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                run_reg     <= run_next;
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                elapsed_reg <= elapsed_next;
                latch_reg   <= latch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_tick_reg <= us_tick;
            s1_req_reg  <= req_type;
        end
        if (adv)
        begin
            out_coil_reg <= latch_next;
            out_pos_reg  <= pos_next;
            out_run_reg  <= run_next;
            out_step_reg <= step_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coil_drive = out_coil_reg;
    assign position   = out_pos_reg;
    assign running    = out_run_reg;
    assign stepped    = out_step_reg;

    // a step only happens while running
    a_step_running: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && step_c) |-> run_next)
        else $error("step taken while stopped");

    // timer restarts after every step
    a_step_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && step_c) |=> (elapsed_reg == '0))
        else $error("timer not cleared after step");

    // position moves only on a step
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !step_c) |=> (pos_reg == $past(pos_reg)))
        else $error("position changed without a step");

    // coil latch holds idle or one of the four patterns
    a_coil_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (latch_reg == 4'd0 || latch_reg == 4'd5 || latch_reg == 4'd6 ||
         latch_reg == 4'd10 || latch_reg == 4'd9))
        else $error("illegal coil pattern");

    // state moves only when the input stage hands an item on
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(pos_reg) && $stable(run_reg) && $stable(latch_reg)))
        else $error("state changed without an item");

endmodule
